>>> src/gsc_pkg.sv
// Shared types, constants and the cell location helper of the grid snap block.
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  localparam int CELL_COUNT_DEF = 131072;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int COORD_W = 20;
  localparam int SITE_W  = 12;
  localparam int CX_W    = 9;
  localparam int CY_W    = 8;
  localparam int LOC_W   = CX_W + CY_W;
  localparam int DIST_W  = 16;
  localparam int GW_W    = 10;
  localparam int GH_W    = 9;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [GW_W-1:0] GRID_W_MAX   = 10'd512;
  localparam logic [GH_W-1:0] GRID_H_MAX   = 9'd256;
  localparam logic [GW_W-1:0] GRID_W_RESET = 10'd301;
  localparam logic [GH_W-1:0] GRID_H_RESET = 9'd225;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    JK_PLACE   = 2'd0,
    JK_DRAIN   = 2'd1,
    JK_OUTSIDE = 2'd2
  } job_kind_e;

  typedef enum logic [2:0] {
    RK_NEW_REJ  = 3'd0,
    RK_DISP_REJ = 3'd1,
    RK_OUTSIDE  = 3'd2,
    RK_KEPT     = 3'd3,
    RK_NONE     = 3'd4
  } res_kind_e;

  typedef struct packed {
    job_kind_e          kind;
    logic [SITE_W-1:0]  site;
    logic [CX_W-1:0]    cx;
    logic [CY_W-1:0]    cy;
    logic [DIST_W-1:0]  dsq;
  } job_t;

  typedef struct packed {
    res_kind_e          kind;
    logic [SITE_W-1:0]  site;
    logic [CX_W-1:0]    cx;
    logic [CY_W-1:0]    cy;
    logic [DIST_W-1:0]  dsq;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               taken;
    logic [DIST_W-1:0]  dsq;
    logic [SITE_W-1:0]  site;
  } cell_t;

  function automatic logic [LOC_W-1:0] cell_loc(input logic [CX_W-1:0] cx,
                                                input logic [CY_W-1:0] cy);
    return {cy, cx};
  endfunction

endpackage

`default_nettype wire

>>> src/gsc_fifo.sv
// Small register queue used between the stages and on the result side.
`timescale 1ns / 1ps
`default_nettype none

module gsc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/gsc_front.sv
// Front end: accepts requests, rounds coordinates, classifies and computes distance.
`timescale 1ns / 1ps
`default_nettype none

module gsc_front #(
  parameter int CELL_COUNT = gsc_pkg::CELL_COUNT_DEF,
  parameter int FRAC_BITS  = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [gsc_pkg::SITE_W-1:0]    site_index_i,
  input  wire logic signed [gsc_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic signed [gsc_pkg::COORD_W-1:0] y_coord_i,
  input  wire logic [gsc_pkg::GW_W-1:0]      grid_width_i,
  input  wire logic [gsc_pkg::GH_W-1:0]      grid_height_i,
  output logic                               job_valid_o,
  input  wire logic                          job_ready_i,
  output gsc_pkg::job_t                      job_o
);

  localparam int CW    = gsc_pkg::COORD_W;
  localparam int RW    = CW - FRAC_BITS;
  localparam int SQ_W  = 2 * FRAC_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int SH_L  = (SQ_W < gsc_pkg::DIST_W) ? gsc_pkg::DIST_W - SQ_W : 0;
  localparam int SH_R  = (SQ_W > gsc_pkg::DIST_W) ? SQ_W - gsc_pkg::DIST_W : 0;
  localparam int SC_W  = SUM_W + SH_L;
  localparam logic [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

  logic [CW-1:0]        crd  [2];
  logic [CW-1:0]        mag  [2];
  logic [CW-1:0]        rsum [2];
  logic [RW-1:0]        rnd  [2];
  logic [FRAC_BITS-1:0] frac [2];
  logic [FRAC_BITS-1:0] off  [2];
  logic                 below_zero [2];

  logic [gsc_pkg::GW_W-1:0]  gw_sat;
  logic [gsc_pkg::GH_W-1:0]  gh_sat;
  logic [gsc_pkg::CX_W-1:0]  rx;
  logic [gsc_pkg::CY_W-1:0]  ry;
  logic                      in_grid;
  logic                      load;

  logic                      stg_valid_q, stg_valid_d;
  logic                      stg_drain_q, stg_in_grid_q;
  logic [gsc_pkg::SITE_W-1:0] stg_site_q;
  logic [gsc_pkg::CX_W-1:0]  stg_cx_q;
  logic [gsc_pkg::CY_W-1:0]  stg_cy_q;
  logic [FRAC_BITS-1:0]      stg_offx_q, stg_offy_q;

  logic [SQ_W-1:0]           sqx, sqy;
  logic [SUM_W-1:0]          sq_sum;
  logic [SC_W-1:0]           scaled;
  logic [gsc_pkg::DIST_W-1:0] dsq_val;

  assign crd[0] = x_coord_i;
  assign crd[1] = y_coord_i;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      mag[i]        = crd[i][CW-1] ? (~crd[i] + 1'b1) : crd[i];
      rsum[i]       = mag[i] + HALF;
      rnd[i]        = rsum[i][CW-1:FRAC_BITS];
      frac[i]       = mag[i][FRAC_BITS-1:0];
      off[i]        = frac[i][FRAC_BITS-1] ? (~frac[i] + 1'b1) : frac[i];
      below_zero[i] = crd[i][CW-1] && (rnd[i] != '0);
    end
  end

  assign gw_sat = (grid_width_i > gsc_pkg::GRID_W_MAX) ? gsc_pkg::GRID_W_MAX : grid_width_i;
  assign gh_sat = (grid_height_i > gsc_pkg::GRID_H_MAX) ? gsc_pkg::GRID_H_MAX : grid_height_i;
  assign rx     = gsc_pkg::CX_W'(rnd[0]);
  assign ry     = gsc_pkg::CY_W'(rnd[1]);

  assign in_grid = !below_zero[0] && !below_zero[1]
                && (32'(rnd[0]) < 32'(gw_sat))
                && (32'(rnd[1]) < 32'(gh_sat))
                && (32'(gsc_pkg::cell_loc(rx, ry)) < 32'(CELL_COUNT));

  assign in_ready_o  = !stg_valid_q || job_ready_i;
  assign load        = in_valid_i && in_ready_o;
  assign stg_valid_d = in_ready_o ? in_valid_i : stg_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stg_drain_q   <= req_type_i;
      stg_in_grid_q <= in_grid;
      stg_site_q    <= site_index_i;
      stg_cx_q      <= rx;
      stg_cy_q      <= ry;
      stg_offx_q    <= off[0];
      stg_offy_q    <= off[1];
    end
  end

  assign sqx     = SQ_W'(stg_offx_q) * SQ_W'(stg_offx_q);
  assign sqy     = SQ_W'(stg_offy_q) * SQ_W'(stg_offy_q);
  assign sq_sum  = SUM_W'(sqx) + SUM_W'(sqy);
  assign scaled  = (SC_W'(sq_sum) << SH_L) >> SH_R;
  assign dsq_val = (scaled > SC_W'(16'hFFFF)) ? 16'hFFFF : scaled[gsc_pkg::DIST_W-1:0];

  always_comb begin
    job_o      = '0;
    job_o.site = stg_site_q;
    if (stg_drain_q) begin
      job_o.kind = gsc_pkg::JK_DRAIN;
    end else if (!stg_in_grid_q) begin
      job_o.kind = gsc_pkg::JK_OUTSIDE;
    end else begin
      job_o.kind = gsc_pkg::JK_PLACE;
      job_o.cx   = stg_cx_q;
      job_o.cy   = stg_cy_q;
      job_o.dsq  = dsq_val;
    end
  end

  assign job_valid_o = stg_valid_q;

endmodule

`default_nettype wire

>>> src/gsc_back.sv
// Back end: cell store, claim list and the sequencer that updates and drains them.
`timescale 1ns / 1ps
`default_nettype none

module gsc_back #(
  parameter int CELL_COUNT = gsc_pkg::CELL_COUNT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire gsc_pkg::job_t job_i,
  input  wire logic  job_empty_i,
  output logic       job_pop_o,
  output gsc_pkg::res_t res_o,
  output logic       res_push_o,
  input  wire logic  res_full_i,
  output logic       clearing_o
);

  localparam int AW    = $clog2(CELL_COUNT);
  localparam int CNT_W = $clog2(CELL_COUNT + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_DLOC,
    ST_DOUT
  } state_e;

  state_e state_q, state_d;

  gsc_pkg::cell_t cell_mem [CELL_COUNT];
  logic [gsc_pkg::LOC_W-1:0] order_mem [CELL_COUNT];

  gsc_pkg::cell_t            cell_rdata_q, cell_wdata;
  logic [gsc_pkg::LOC_W-1:0] order_rdata_q;
  logic                      cell_we, cell_re, order_we, order_re;
  logic [AW-1:0]             cell_waddr, cell_raddr, order_raddr;

  logic [AW-1:0]             clr_q, clr_d;
  logic [CNT_W-1:0]          claim_q, claim_d, drain_q, drain_d;
  gsc_pkg::job_t             job_q, job_d;
  logic                      last_q, last_d;
  logic [gsc_pkg::LOC_W-1:0] loc_q, loc_d;
  logic [gsc_pkg::LOC_W-1:0] job_loc;

  assign job_loc    = gsc_pkg::cell_loc(job_q.cx, job_q.cy);
  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    claim_d     = claim_q;
    drain_d     = drain_q;
    job_d       = job_q;
    last_d      = last_q;
    loc_d       = loc_q;
    job_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;
    cell_we     = 1'b0;
    cell_re     = 1'b0;
    cell_waddr  = AW'(job_loc);
    cell_raddr  = AW'(gsc_pkg::cell_loc(job_i.cx, job_i.cy));
    cell_wdata  = '0;
    order_we    = 1'b0;
    order_re    = 1'b0;
    order_raddr = drain_q[AW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        if (clr_q == AW'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!job_empty_i) begin
          unique case (job_i.kind)
            gsc_pkg::JK_PLACE: begin
              job_pop_o = 1'b1;
              job_d     = job_i;
              cell_re   = 1'b1;
              state_d   = ST_PLACE;
            end
            gsc_pkg::JK_DRAIN: begin
              if (drain_q < claim_q) begin
                job_pop_o = 1'b1;
                order_re  = 1'b1;
                drain_d   = drain_q + 1'b1;
                last_d    = (drain_q + 1'b1 == claim_q);
                state_d   = ST_DLOC;
              end else if (!res_full_i) begin
                job_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o.kind = gsc_pkg::RK_NONE;
              end
            end
            gsc_pkg::JK_OUTSIDE: begin
              if (!res_full_i) begin
                job_pop_o  = 1'b1;
                res_push_o = 1'b1;
                res_o.kind = gsc_pkg::RK_OUTSIDE;
                res_o.site = job_i.site;
              end
            end
            default: begin
              job_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_PLACE: begin
        cell_wdata.taken = 1'b1;
        cell_wdata.dsq   = job_q.dsq;
        cell_wdata.site  = job_q.site;
        res_o.cx         = job_q.cx;
        res_o.cy         = job_q.cy;
        priority if (!cell_rdata_q.taken) begin
          cell_we = 1'b1;
          if (claim_q < CNT_W'(CELL_COUNT)) begin
            order_we = 1'b1;
            claim_d  = claim_q + 1'b1;
          end
          state_d = ST_IDLE;
        end else if (job_q.dsq < cell_rdata_q.dsq) begin
          if (!res_full_i) begin
            cell_we    = 1'b1;
            res_push_o = 1'b1;
            res_o.kind = gsc_pkg::RK_DISP_REJ;
            res_o.site = cell_rdata_q.site;
            res_o.dsq  = cell_rdata_q.dsq;
            state_d    = ST_IDLE;
          end
        end else begin
          if (!res_full_i) begin
            res_push_o = 1'b1;
            res_o.kind = gsc_pkg::RK_NEW_REJ;
            res_o.site = job_q.site;
            res_o.dsq  = job_q.dsq;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_DLOC: begin
        loc_d      = order_rdata_q;
        cell_re    = 1'b1;
        cell_raddr = AW'(order_rdata_q);
        state_d    = ST_DOUT;
      end
      ST_DOUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.kind = gsc_pkg::RK_KEPT;
          res_o.site = cell_rdata_q.site;
          res_o.cx   = loc_q[gsc_pkg::CX_W-1:0];
          res_o.cy   = loc_q[gsc_pkg::LOC_W-1:gsc_pkg::CX_W];
          res_o.dsq  = cell_rdata_q.dsq;
          res_o.last = last_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      claim_q <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      claim_q <= claim_d;
      drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    last_q <= last_d;
    loc_q  <= loc_d;
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (order_we) begin
      order_mem[claim_q[AW-1:0]] <= job_loc;
    end
    if (order_re) begin
      order_rdata_q <= order_mem[order_raddr];
    end
  end

endmodule

`default_nettype wire

>>> src/grid_snap_closest_per_cell.sv
// Top level of the grid snap block: config registers, front end, queues and back end.
//
//   channel   direction  handshake            payload
//   request   in         push / full          req_type_i site_index_i x_coord_i y_coord_i
//   result    out        empty / pop          result_kind_o out_site_o cell_x_o cell_y_o
//                                             dist_sq_o last_kept_o
//   config    in         cfg_we_i             cfg_idx_i cfg_wdata_i
//
// A request passes one front register stage, then the back end handles a placement as a
// cell store read followed by a write, a drain as a claim list read, a cell store read and
// the result push, and an outside or none-left result straight from idle; it takes the
// next job only once it is back in idle.
// After reset the back end clears every cell of the store while full is held high.
// Each side stalls on its own through a two-entry queue between front and back and a
// two-entry result queue.
`timescale 1ns / 1ps
`default_nettype none

module grid_snap_closest_per_cell #(
  parameter int CELL_COUNT = gsc_pkg::CELL_COUNT_DEF,
  parameter int FRAC_BITS  = gsc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               req_type_i,
  input  wire logic [gsc_pkg::SITE_W-1:0]         site_index_i,
  input  wire logic signed [gsc_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic signed [gsc_pkg::COORD_W-1:0] y_coord_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [2:0]                              result_kind_o,
  output logic [gsc_pkg::SITE_W-1:0]              out_site_o,
  output logic [gsc_pkg::CX_W-1:0]                cell_x_o,
  output logic [gsc_pkg::CY_W-1:0]                cell_y_o,
  output logic [gsc_pkg::DIST_W-1:0]              dist_sq_o,
  output logic                                    last_kept_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [gsc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [gsc_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int JOB_W = $bits(gsc_pkg::job_t);
  localparam int RES_W = $bits(gsc_pkg::res_t);

  logic [gsc_pkg::GW_W-1:0] grid_width_q, grid_width_d;
  logic [gsc_pkg::GH_W-1:0] grid_height_q, grid_height_d;

  logic          front_ready, front_valid, clearing;
  gsc_pkg::job_t front_job, back_job;
  logic          mid_full, mid_empty, mid_pop;
  gsc_pkg::res_t back_res, head_res;
  logic          res_push, res_full;
  logic [JOB_W-1:0] back_job_bits;
  logic [RES_W-1:0] head_res_bits;

  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gsc_pkg::REG_GRID_WIDTH:  grid_width_d  = cfg_wdata_i;
        gsc_pkg::REG_GRID_HEIGHT: grid_height_d = cfg_wdata_i[gsc_pkg::GH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= gsc_pkg::GRID_W_RESET;
      grid_height_q <= gsc_pkg::GRID_H_RESET;
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
    end
  end

  assign full = clearing || !front_ready;

  gsc_front #(
    .CELL_COUNT (CELL_COUNT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (push && !full),
    .in_ready_o    (front_ready),
    .req_type_i    (req_type_i),
    .site_index_i  (site_index_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .job_valid_o   (front_valid),
    .job_ready_i   (!mid_full),
    .job_o         (front_job)
  );

  gsc_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid && !mid_full),
    .data_i  (front_job),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (back_job_bits),
    .empty_o (mid_empty)
  );

  assign back_job = gsc_pkg::job_t'(back_job_bits);

  gsc_back #(
    .CELL_COUNT (CELL_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_empty_i (mid_empty),
    .job_pop_o   (mid_pop),
    .res_o       (back_res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .clearing_o  (clearing)
  );

  gsc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .data_o  (head_res_bits),
    .empty_o (empty)
  );

  assign head_res      = gsc_pkg::res_t'(head_res_bits);
  assign result_kind_o = head_res.kind;
  assign out_site_o    = head_res.site;
  assign cell_x_o      = head_res.cx;
  assign cell_y_o      = head_res.cy;
  assign dist_sq_o     = head_res.dsq;
  assign last_kept_o   = head_res.last;

`ifndef SYNTH
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("request side open during store clear");

  a_last_only_on_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o != gsc_pkg::RK_KEPT) |-> !last_kept_o)
    else $error("last flag on a result that is not a kept winner");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == gsc_pkg::RK_OUTSIDE)
      |-> (cell_x_o == '0 && cell_y_o == '0 && dist_sq_o == '0))
    else $error("outside result carries cell fields");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_kind_o == gsc_pkg::RK_NONE) |-> (out_site_o == '0))
    else $error("none-left result carries a site");
`endif

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for grid_snap_closest_per_cell: cell claims, rejections, drains.
`timescale 1ns / 1ps

module tb;
  import gsc_pkg::*;

  localparam int CELLS       = CELL_COUNT_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int ONE         = 1 << FRAC;
  localparam int ROW_STRIDE  = 1 << CX_W;
  localparam int SETTLE_GAP  = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 600000;

  typedef struct packed {
    logic               drain;
    logic [SITE_W-1:0]  site;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } site_req_t;

  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      push         = 1'b0;
  logic                      full;
  logic                      req_type_i   = 1'b0;
  logic [SITE_W-1:0]         site_index_i = '0;
  logic signed [COORD_W-1:0] x_coord_i    = '0;
  logic signed [COORD_W-1:0] y_coord_i    = '0;
  logic                      empty;
  logic                      pop          = 1'b0;
  logic [2:0]                result_kind_o;
  logic [SITE_W-1:0]         out_site_o;
  logic [CX_W-1:0]           cell_x_o;
  logic [CY_W-1:0]           cell_y_o;
  logic [DIST_W-1:0]         dist_sq_o;
  logic                      last_kept_o;
  logic                      cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i    = '0;
  logic [CFG_W-1:0]          cfg_wdata_i  = '0;

  grid_snap_closest_per_cell i_dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow of the block: config and per-cell winners.
  logic [GW_W-1:0]   grid_cols = GRID_W_RESET;
  logic [GH_W-1:0]   grid_rows = GRID_H_RESET;
  logic              taken_map  [CELLS];
  logic [DIST_W-1:0] best_dist  [CELLS];
  logic [SITE_W-1:0] best_site  [CELLS];
  logic [LOC_W-1:0]  claim_list [CELLS];
  int unsigned       claims  = 0;
  int unsigned       drained = 0;

  site_req_t   site_reqs[$];
  res_t        outcomes_due[$];
  site_req_t   next_req;
  int unsigned reqs_queued  = 0;
  int unsigned reqs_taken   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int          send_idle    = 0;
  int          recv_idle    = 0;
  logic        sent_ok      = 1'b0;
  logic        hold_req     = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_left    = 0;

  function automatic int snap(input logic signed [COORD_W-1:0] v, output int unsigned off);
    int m;
    int r;
    m = v;
    if (m < 0) m = -m;
    r = (m + (1 << (FRAC - 1))) >> FRAC;
    off = ((r << FRAC) > m) ? (r << FRAC) - m : m - (r << FRAC);
    return (v < 0) ? -r : r;
  endfunction

  task automatic judge_request(input site_req_t rq);
    res_t              r;
    int                rx;
    int                ry;
    int                lim_w;
    int                lim_h;
    int unsigned       ox;
    int unsigned       oy;
    int unsigned       sq;
    logic [LOC_W-1:0]  loc;
    logic [DIST_W-1:0] d;
    r = '0;
    if (rq.drain) begin
      if (drained < claims) begin
        loc    = claim_list[drained];
        r.kind = RK_KEPT;
        r.site = best_site[loc];
        r.cx   = loc[CX_W-1:0];
        r.cy   = loc[LOC_W-1:CX_W];
        r.dsq  = best_dist[loc];
        r.last = (drained + 1 == claims);
        drained++;
      end else begin
        r.kind = RK_NONE;
      end
      outcomes_due.insert(outcomes_due.size(), r);
      return;
    end
    rx = snap(rq.x, ox);
    ry = snap(rq.y, oy);
    lim_w = (grid_cols > GRID_W_MAX) ? GRID_W_MAX : grid_cols;
    lim_h = (grid_rows > GRID_H_MAX) ? GRID_H_MAX : grid_rows;
    if (rx < 0 || ry < 0 || rx >= lim_w || ry >= lim_h || ry * ROW_STRIDE + rx >= CELLS) begin
      r.kind = RK_OUTSIDE;
      r.site = rq.site;
      outcomes_due.insert(outcomes_due.size(), r);
      return;
    end
    loc = {ry[CY_W-1:0], rx[CX_W-1:0]};
    sq = ox * ox + oy * oy;
    if (2 * FRAC > 16) sq = sq >> (2 * FRAC - 16);
    else sq = sq << (16 - 2 * FRAC);
    d = (sq > 32'hFFFF) ? 16'hFFFF : sq[DIST_W-1:0];
    if (!taken_map[loc]) begin
      taken_map[loc] = 1'b1;
      best_dist[loc] = d;
      best_site[loc] = rq.site;
      if (claims < CELLS) begin
        claim_list[claims] = loc;
        claims++;
      end
      return;
    end
    r.cx = rx[CX_W-1:0];
    r.cy = ry[CY_W-1:0];
    if (d < best_dist[loc]) begin
      r.kind = RK_DISP_REJ;
      r.site = best_site[loc];
      r.dsq  = best_dist[loc];
      best_dist[loc] = d;
      best_site[loc] = rq.site;
    end else begin
      r.kind = RK_NEW_REJ;
      r.site = rq.site;
      r.dsq  = d;
    end
    outcomes_due.insert(outcomes_due.size(), r);
  endtask

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_outcome();
    res_t want;
    if (outcomes_due.size() == 0) begin
      $display("%0t: unexpected result expected none got kind %0d site %0h",
               $time, result_kind_o, out_site_o);
      mismatches++;
    end else begin
      want = outcomes_due.pop_front();
      check_field("result_kind", want.kind, result_kind_o);
      check_field("out_site", want.site, out_site_o);
      check_field("cell_x", want.cx, cell_x_o);
      check_field("cell_y", want.cy, cell_y_o);
      check_field("dist_sq", want.dsq, dist_sq_o);
      check_field("last_kept", want.last, last_kept_o);
    end
  endtask

  // Monitor: predict accepted requests, check popped results, watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      sent_ok <= push && !full;
      if (push && !full) begin
        judge_request(site_req_t'{req_type_i, site_index_i, x_coord_i, y_coord_i});
        reqs_taken++;
      end
      if (pop && !empty) check_outcome();
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: hold a request until taken, then advance.
  always @(negedge clk_i) begin
    if (!push || sent_ok) begin
      if (rst_ni && site_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        next_req     = site_reqs.pop_front();
        push         <= 1'b1;
        req_type_i   <= next_req.drain;
        site_index_i <= next_req.site;
        x_coord_i    <= next_req.x;
        y_coord_i    <= next_req.y;
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  function automatic site_req_t place(input int site, input int x, input int y);
    site_req_t q;
    q.drain = 1'b0;
    q.site  = site[SITE_W-1:0];
    q.x     = x[COORD_W-1:0];
    q.y     = y[COORD_W-1:0];
    return q;
  endfunction

  function automatic site_req_t drain_req();
    site_req_t q;
    q      = place($urandom_range(0, 4095), $urandom_range(0, 20'hFFFFF),
                   $urandom_range(0, 20'hFFFFF));
    q.drain = 1'b1;
    return q;
  endfunction

  function automatic int frac_offset();
    int f;
    if ($urandom_range(0, 1)) f = $urandom_range(0, ONE - 1);
    else f = int'($urandom_range(0, 4)) * (ONE / 4);
    return f - ONE / 2;
  endfunction

  function automatic site_req_t make_req(input int drain_pct);
    int lw;
    int lh;
    int cx;
    int cy;
    int pick;
    lw = (grid_cols > GRID_W_MAX) ? GRID_W_MAX : grid_cols;
    lh = (grid_rows > GRID_H_MAX) ? GRID_H_MAX : grid_rows;
    if (lw == 0) lw = 8;
    if (lh == 0) lh = 8;
    pick = $urandom_range(0, 99);
    if (pick < drain_pct) return drain_req();
    if (pick < drain_pct + 10) begin
      return place($urandom_range(0, 4095), $urandom_range(0, 20'hFFFFF),
                   $urandom_range(0, 20'hFFFFF));
    end
    cx = $urandom_range(0, lw - 1);
    cy = $urandom_range(0, lh - 1);
    if (pick < drain_pct + 18) begin
      if ($urandom_range(0, 1)) cx = $urandom_range(0, 1) ? lw : -1;
      else cy = $urandom_range(0, 1) ? lh : -1;
    end
    return place($urandom_range(0, 4095), cx * ONE + frac_offset(), cy * ONE + frac_offset());
  endfunction

  task automatic add_req(input site_req_t rq);
    site_reqs.insert(site_reqs.size(), rq);
  endtask

  task automatic queue_random(input int n, input int drain_pct);
    repeat (n) add_req(make_req(drain_pct));
    reqs_queued += n;
  endtask

  task automatic settle();
    while (reqs_taken != reqs_queued || outcomes_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_GAP) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_GRID_WIDTH) grid_cols = val[GW_W-1:0];
    else grid_rows = val[GH_W-1:0];
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle = 27;
        recv_idle = 53;
      end
      1: begin
        send_idle = 53;
        recv_idle = 27;
      end
      default: begin
        send_idle = 0;
        recv_idle = 0;
      end
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows,
                           input int n, input int drain_pct, input int mode);
    settle();
    write_reg(REG_GRID_WIDTH, cols);
    write_reg(REG_GRID_HEIGHT, rows);
    @(posedge clk_i);
    set_idle(mode);
    queue_random(n, drain_pct);
  endtask

  initial begin
    foreach (taken_map[i]) taken_map[i] = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    set_idle(0);

    add_req(drain_req());
    add_req(place(12'hFFF, 0, 0));
    add_req(place(12'h000, 0, 0));
    add_req(place(1, 300 * ONE + ONE / 2 - 1, 224 * ONE - ONE / 2));
    add_req(place(2, 300 * ONE - ONE / 2, 224 * ONE + ONE / 2));
    add_req(place(3, 301 * ONE, 0));
    add_req(place(4, 300 * ONE - ONE / 2, 224 * ONE + ONE / 2 - 1));
    add_req(place(5, 300 * ONE + 1, 224 * ONE));
    add_req(place(6, -ONE / 2, 0));
    add_req(place(7, -ONE / 2 + 1, -ONE / 2 + 1));
    add_req(place(8, -524288, -524288));
    add_req(place(9, 524287, 524287));
    add_req(place(10, 524287, 0));
    add_req(place(11, 0, -524288));
    add_req(drain_req());
    add_req(place(12, 10 * ONE, 20 * ONE));
    repeat (4) add_req(drain_req());
    reqs_queued += 20;
    queue_random(150, 12);

    run_phase(10'h3FF, 10'h3FF, 150, 10, 0);
    run_phase(0, 7, 60, 50, 0);
    run_phase(6, 5, 450, 15, 1);
    run_phase(1, 1, 120, 10, 1);
    hold_req = 1'b1;
    run_phase(40, 256, 250, 12, 2);
    run_phase(512, 0, 40, 30, 2);
    run_phase(300, 20, 200, 12, 2);

    // Empty the claim list and run past its end.
    settle();
    @(posedge clk_i);
    repeat (claims - drained + 2) add_req(drain_req());
    reqs_queued += claims - drained + 2;
    settle();

    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
